>>> rtl/dft9_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft9_pkg: shared types, constants and microcode for the nine-point DFT engine
// Instruction format, coefficient codes, exact coefficient rounding and the
// forward and backward microprograms run by the sequencer.
// ----------------------------------------------------------------------------
package dft9_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 18;
	localparam int COEF_FRAC_BITS_DEF = 16;
	// intermediate growth over the sample width (sums of nine, doublings)
	localparam int DATA_HEADROOM      = 6;

	localparam int VALUE_W = 24;
	localparam int INDEX_W = 4;
	localparam int FILL_W  = 4;
	localparam int RA_W    = 5;
	localparam int NUM_REGS = 31;
	localparam int PC_W    = 7;

	localparam int FWD_LEN  = 67;
	localparam int BWD_LEN  = 59;
	localparam int PROG_LEN = FWD_LEN + BWD_LEN;

	localparam logic [PC_W-1:0]    FWD_START  = PC_W'(0);
	localparam logic [PC_W-1:0]    BWD_START  = PC_W'(FWD_LEN);
	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(8);
	localparam logic [FILL_W-1:0]  LAST_FILL  = FILL_W'(8);

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam longint unsigned DEC_ONE = 64'd1000000000000000000;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_NEG,
		OP_MUL,
		OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		K_C40,
		K_S40,
		K_C80,
		K_S80,
		K_HALF,
		K_S60,
		K_C20,
		K_S20,
		K_R3,
		K_B9,
		K_B10,
		K_B11,
		K_B12,
		K_NS60,
		K_NONE
	} coef_t;

	typedef struct packed {
		op_t             op;
		logic [RA_W-1:0] dst;
		logic [RA_W-1:0] a;
		logic [RA_W-1:0] b;
		coef_t           k;
	} uinstr_t;

	typedef struct packed {
		logic            we;
		logic [RA_W-1:0] waddr;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
	} rf_ctl_t;

	// round(c * 2^frac) to nearest, ties up, exact from the decimal expansion
	function automatic longint coef_round(coef_t k, int frac);
		longint unsigned c;
		longint unsigned q;
		longint unsigned r;
		logic            neg;
		neg = 1'b0;
		case (k)
			K_C40:   c = 64'd766044443118978035;
			K_S40:   c = 64'd642787609686539326;
			K_C80:   c = 64'd173648177666930349;
			K_S80:   c = 64'd984807753012208059;
			K_HALF:  c = 64'd500000000000000000;
			K_S60:   c = 64'd866025403784438647;
			K_C20:   c = 64'd939692620785908384;
			K_S20:   c = 64'd342020143325668733;
			K_R3:    c = 64'd1732050807568877294;
			K_B9:    c = 64'd1705737063904886419;
			K_B10:   c = 64'd300767466360870593;
			K_B11:   c = 64'd1113340798452838733;
			K_B12:   c = 64'd1326827896337876792;
			K_NS60: begin
				c   = 64'd866025403784438647;
				neg = 1'b1;
			end
			default: c = 64'd0;
		endcase
		q = c / DEC_ONE;
		r = c % DEC_ONE;
		for (int i = 0; i < frac; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= DEC_ONE) begin
				q = q + 64'd1;
				r = r - DEC_ONE;
			end
		end
		if ((r << 1) >= DEC_ONE)
			q = q + 64'd1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic uinstr_t mk(op_t op, logic [RA_W-1:0] dst, logic [RA_W-1:0] a,
		logic [RA_W-1:0] b, coef_t k);
		uinstr_t u;
		u.op  = op;
		u.dst = dst;
		u.a   = a;
		u.b   = b;
		u.k   = k;
		return u;
	endfunction

	// Registers 0..8 hold the frame, 9..30 are scratch.
	localparam uinstr_t UCODE [PROG_LEN] = '{
		// forward: butterflies
		mk(OP_ADD, 5'd9,  5'd1,  5'd8,  K_NONE),
		mk(OP_SUB, 5'd10, 5'd1,  5'd8,  K_NONE),
		mk(OP_ADD, 5'd11, 5'd2,  5'd7,  K_NONE),
		mk(OP_SUB, 5'd12, 5'd2,  5'd7,  K_NONE),
		mk(OP_ADD, 5'd13, 5'd3,  5'd6,  K_NONE),
		mk(OP_SUB, 5'd14, 5'd3,  5'd6,  K_NONE),
		mk(OP_ADD, 5'd15, 5'd4,  5'd5,  K_NONE),
		mk(OP_SUB, 5'd16, 5'd4,  5'd5,  K_NONE),
		mk(OP_ADD, 5'd17, 5'd9,  5'd15, K_NONE),
		mk(OP_ADD, 5'd17, 5'd17, 5'd11, K_NONE),
		mk(OP_SUB, 5'd18, 5'd10, 5'd12, K_NONE),
		mk(OP_ADD, 5'd18, 5'd18, 5'd16, K_NONE),
		mk(OP_MUL, 5'd19, 5'd14, 5'd0,  K_S60),
		mk(OP_MUL, 5'd20, 5'd13, 5'd0,  K_HALF),
		mk(OP_SUB, 5'd20, 5'd0,  5'd20, K_NONE),
		// X0
		mk(OP_ADD, 5'd21, 5'd17, 5'd13, K_NONE),
		mk(OP_ADD, 5'd21, 5'd21, 5'd0,  K_NONE),
		mk(OP_OUT, 5'd0,  5'd21, 5'd0,  K_NONE),
		// re X1
		mk(OP_MUL, 5'd22, 5'd9,  5'd0,  K_C40),
		mk(OP_MUL, 5'd23, 5'd11, 5'd0,  K_C80),
		mk(OP_ADD, 5'd22, 5'd20, 5'd22, K_NONE),
		mk(OP_ADD, 5'd22, 5'd22, 5'd23, K_NONE),
		mk(OP_MUL, 5'd23, 5'd15, 5'd0,  K_C20),
		mk(OP_SUB, 5'd22, 5'd22, 5'd23, K_NONE),
		mk(OP_OUT, 5'd0,  5'd22, 5'd0,  K_NONE),
		// im X1
		mk(OP_MUL, 5'd23, 5'd10, 5'd0,  K_S40),
		mk(OP_MUL, 5'd24, 5'd12, 5'd0,  K_S80),
		mk(OP_ADD, 5'd23, 5'd23, 5'd24, K_NONE),
		mk(OP_ADD, 5'd23, 5'd23, 5'd19, K_NONE),
		mk(OP_MUL, 5'd24, 5'd16, 5'd0,  K_S20),
		mk(OP_ADD, 5'd23, 5'd23, 5'd24, K_NONE),
		mk(OP_NEG, 5'd23, 5'd23, 5'd0,  K_NONE),
		mk(OP_OUT, 5'd0,  5'd23, 5'd0,  K_NONE),
		// re X2
		mk(OP_MUL, 5'd24, 5'd15, 5'd0,  K_C40),
		mk(OP_ADD, 5'd24, 5'd20, 5'd24, K_NONE),
		mk(OP_MUL, 5'd25, 5'd9,  5'd0,  K_C80),
		mk(OP_ADD, 5'd24, 5'd24, 5'd25, K_NONE),
		mk(OP_MUL, 5'd25, 5'd11, 5'd0,  K_C20),
		mk(OP_SUB, 5'd24, 5'd24, 5'd25, K_NONE),
		mk(OP_OUT, 5'd0,  5'd24, 5'd0,  K_NONE),
		// im X2
		mk(OP_MUL, 5'd25, 5'd16, 5'd0,  K_S40),
		mk(OP_MUL, 5'd26, 5'd10, 5'd0,  K_S80),
		mk(OP_SUB, 5'd25, 5'd25, 5'd26, K_NONE),
		mk(OP_ADD, 5'd25, 5'd25, 5'd19, K_NONE),
		mk(OP_MUL, 5'd26, 5'd12, 5'd0,  K_S20),
		mk(OP_SUB, 5'd25, 5'd25, 5'd26, K_NONE),
		mk(OP_OUT, 5'd0,  5'd25, 5'd0,  K_NONE),
		// re X3
		mk(OP_ADD, 5'd26, 5'd0,  5'd13, K_NONE),
		mk(OP_MUL, 5'd27, 5'd17, 5'd0,  K_HALF),
		mk(OP_SUB, 5'd26, 5'd26, 5'd27, K_NONE),
		mk(OP_OUT, 5'd0,  5'd26, 5'd0,  K_NONE),
		// im X3
		mk(OP_MUL, 5'd27, 5'd18, 5'd0,  K_NS60),
		mk(OP_OUT, 5'd0,  5'd27, 5'd0,  K_NONE),
		// re X4
		mk(OP_MUL, 5'd28, 5'd11, 5'd0,  K_C40),
		mk(OP_ADD, 5'd28, 5'd20, 5'd28, K_NONE),
		mk(OP_MUL, 5'd29, 5'd15, 5'd0,  K_C80),
		mk(OP_ADD, 5'd28, 5'd28, 5'd29, K_NONE),
		mk(OP_MUL, 5'd29, 5'd9,  5'd0,  K_C20),
		mk(OP_SUB, 5'd28, 5'd28, 5'd29, K_NONE),
		mk(OP_OUT, 5'd0,  5'd28, 5'd0,  K_NONE),
		// im X4
		mk(OP_MUL, 5'd29, 5'd12, 5'd0,  K_S40),
		mk(OP_MUL, 5'd30, 5'd16, 5'd0,  K_S80),
		mk(OP_ADD, 5'd29, 5'd29, 5'd30, K_NONE),
		mk(OP_SUB, 5'd29, 5'd29, 5'd19, K_NONE),
		mk(OP_MUL, 5'd30, 5'd10, 5'd0,  K_S20),
		mk(OP_SUB, 5'd29, 5'd29, 5'd30, K_NONE),
		mk(OP_OUT, 5'd0,  5'd29, 5'd0,  K_NONE),
		// backward: first layer
		mk(OP_MUL, 5'd9,  5'd6,  5'd0,  K_R3),
		mk(OP_SUB, 5'd10, 5'd0,  5'd5,  K_NONE),
		mk(OP_ADD, 5'd11, 5'd5,  5'd5,  K_NONE),
		mk(OP_ADD, 5'd11, 5'd0,  5'd11, K_NONE),
		mk(OP_SUB, 5'd12, 5'd10, 5'd9,  K_NONE),
		mk(OP_ADD, 5'd13, 5'd10, 5'd9,  K_NONE),
		mk(OP_ADD, 5'd14, 5'd7,  5'd3,  K_NONE),
		mk(OP_SUB, 5'd15, 5'd7,  5'd3,  K_NONE),
		mk(OP_MUL, 5'd15, 5'd15, 5'd0,  K_S60),
		mk(OP_ADD, 5'd16, 5'd8,  5'd4,  K_NONE),
		mk(OP_MUL, 5'd16, 5'd16, 5'd0,  K_S60),
		mk(OP_SUB, 5'd17, 5'd4,  5'd8,  K_NONE),
		mk(OP_ADD, 5'd18, 5'd1,  5'd14, K_NONE),
		mk(OP_MUL, 5'd19, 5'd17, 5'd0,  K_HALF),
		mk(OP_ADD, 5'd19, 5'd2,  5'd19, K_NONE),
		mk(OP_ADD, 5'd20, 5'd15, 5'd19, K_NONE),
		mk(OP_SUB, 5'd21, 5'd19, 5'd15, K_NONE),
		mk(OP_MUL, 5'd22, 5'd14, 5'd0,  K_HALF),
		mk(OP_SUB, 5'd22, 5'd1,  5'd22, K_NONE),
		mk(OP_SUB, 5'd23, 5'd22, 5'd16, K_NONE),
		mk(OP_ADD, 5'd24, 5'd22, 5'd16, K_NONE),
		mk(OP_SUB, 5'd25, 5'd11, 5'd18, K_NONE),
		mk(OP_SUB, 5'd26, 5'd2,  5'd17, K_NONE),
		mk(OP_MUL, 5'd26, 5'd26, 5'd0,  K_R3),
		// backward: rotations
		mk(OP_MUL, 5'd27, 5'd23, 5'd0,  K_C40),
		mk(OP_MUL, 5'd28, 5'd20, 5'd0,  K_S40),
		mk(OP_SUB, 5'd27, 5'd27, 5'd28, K_NONE),
		mk(OP_MUL, 5'd28, 5'd23, 5'd0,  K_B11),
		mk(OP_MUL, 5'd29, 5'd20, 5'd0,  K_B12),
		mk(OP_ADD, 5'd28, 5'd28, 5'd29, K_NONE),
		mk(OP_SUB, 5'd29, 5'd12, 5'd27, K_NONE),
		mk(OP_MUL, 5'd30, 5'd24, 5'd0,  K_B9),
		mk(OP_MUL, 5'd9,  5'd21, 5'd0,  K_B10),
		mk(OP_ADD, 5'd30, 5'd30, 5'd9,  K_NONE),
		mk(OP_MUL, 5'd9,  5'd24, 5'd0,  K_C80),
		mk(OP_MUL, 5'd10, 5'd21, 5'd0,  K_S80),
		mk(OP_SUB, 5'd9,  5'd9,  5'd10, K_NONE),
		mk(OP_SUB, 5'd10, 5'd13, 5'd9,  K_NONE),
		// backward: outputs in index order
		mk(OP_ADD, 5'd14, 5'd18, 5'd18, K_NONE),
		mk(OP_ADD, 5'd14, 5'd11, 5'd14, K_NONE),
		mk(OP_OUT, 5'd0,  5'd14, 5'd0,  K_NONE),
		mk(OP_ADD, 5'd15, 5'd27, 5'd27, K_NONE),
		mk(OP_ADD, 5'd15, 5'd12, 5'd15, K_NONE),
		mk(OP_OUT, 5'd0,  5'd15, 5'd0,  K_NONE),
		mk(OP_ADD, 5'd16, 5'd9,  5'd9,  K_NONE),
		mk(OP_ADD, 5'd16, 5'd13, 5'd16, K_NONE),
		mk(OP_OUT, 5'd0,  5'd16, 5'd0,  K_NONE),
		mk(OP_SUB, 5'd17, 5'd25, 5'd26, K_NONE),
		mk(OP_OUT, 5'd0,  5'd17, 5'd0,  K_NONE),
		mk(OP_SUB, 5'd19, 5'd29, 5'd28, K_NONE),
		mk(OP_OUT, 5'd0,  5'd19, 5'd0,  K_NONE),
		mk(OP_SUB, 5'd20, 5'd10, 5'd30, K_NONE),
		mk(OP_OUT, 5'd0,  5'd20, 5'd0,  K_NONE),
		mk(OP_ADD, 5'd21, 5'd25, 5'd26, K_NONE),
		mk(OP_OUT, 5'd0,  5'd21, 5'd0,  K_NONE),
		mk(OP_ADD, 5'd22, 5'd29, 5'd28, K_NONE),
		mk(OP_OUT, 5'd0,  5'd22, 5'd0,  K_NONE),
		mk(OP_ADD, 5'd23, 5'd10, 5'd30, K_NONE),
		mk(OP_OUT, 5'd0,  5'd23, 5'd0,  K_NONE)
	};

endpackage

>>> rtl/real_dft9_halfcomplex_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_dft9_halfcomplex_engine: nine-point real DFT, halfcomplex in and out
// Collects nine samples, then runs a microprogram on one adder and one shared
// constant multiplier to give nine results in index order.
//
//   channel  control        payload
//   -------  -------------  -----------------------------------
//   in       start / busy   sample, batch_last
//   out      valid          value, index, last, batch_end
//   cfg      cfg_we         cfg_wdata (direction)
//
// Samples one through eight are taken one per cycle. The ninth starts the
// program and busy stays high until the last result of the frame is strobed:
// each add, subtract or result step passes a register file read and an
// execute step, and each multiply a read, a product register and a round and
// write back step.
// Result strobes never come back to back; nothing downstream can
// hold them. arst_n clears the control state; the register file is not reset.
// ----------------------------------------------------------------------------
module real_dft9_halfcomplex_engine #(
	parameter int SAMPLE_WIDTH   = dft9_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = dft9_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [SAMPLE_WIDTH-1:0]         sample,
	input  logic                                   batch_last,
	input  logic                                   cfg_we,
	input  logic                                   cfg_wdata,
	output logic                                   valid,
	output logic signed [dft9_pkg::VALUE_W-1:0]    value,
	output logic        [dft9_pkg::INDEX_W-1:0]    index,
	output logic                                   last,
	output logic                                   batch_end
);
	import dft9_pkg::*;

	localparam int DW    = SAMPLE_WIDTH + DATA_HEADROOM;
	localparam int SAT_W = (DW > VALUE_W) ? DW : VALUE_W;

	typedef enum logic [1:0] {
		S_FILL,
		S_FETCH,
		S_EXEC,
		S_MULW
	} state_t;

	state_t                state_q;
	logic [PC_W-1:0]       pc_q;
	logic [FILL_W-1:0]     fill_cnt_q;
	logic [INDEX_W-1:0]    out_cnt_q;
	logic                  batch_q;
	logic                  dir_q;
	logic                  valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  last_q;
	logic                  batch_end_q;

	uinstr_t               instr;
	rf_ctl_t               rf_ctl;
	logic signed [DW-1:0]  rf_wdata;
	logic signed [DW-1:0]  rd_a;
	logic signed [DW-1:0]  rd_b;
	logic signed [DW-1:0]  alu_res;
	logic signed [DW-1:0]  mul_res;
	logic signed [SAT_W-1:0] out_ext;
	logic signed [VALUE_W-1:0] sat_val;
	logic                  accept;

	assign instr  = UCODE[pc_q];
	assign busy   = (state_q != S_FILL);
	assign accept = start && !busy;

	dft9_regfile #(
		.DW(DW)
	) u_regfile (
		.clk     (clk),
		.ctl     (rf_ctl),
		.wdata   (rf_wdata),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	dft9_mulr #(
		.DW   (DW),
		.FRAC (COEF_FRAC_BITS)
	) u_mulr (
		.clk     (clk),
		.operand (rd_a),
		.k       (instr.k),
		.result  (mul_res)
	);

	always_comb begin
		case (instr.op)
			OP_ADD:  alu_res = rd_a + rd_b;
			OP_SUB:  alu_res = rd_a - rd_b;
			OP_NEG:  alu_res = -rd_a;
			default: alu_res = rd_a;
		endcase
	end

	// clamp to the output range
	assign out_ext = SAT_W'(rd_a);
	always_comb begin
		if (out_ext > SAT_W'(VALUE_MAX))
			sat_val = VALUE_MAX;
		else if (out_ext < SAT_W'(VALUE_MIN))
			sat_val = VALUE_MIN;
		else
			sat_val = out_ext[VALUE_W-1:0];
	end

	always_comb begin
		rf_ctl.ra    = instr.a;
		rf_ctl.rb    = instr.b;
		rf_ctl.we    = 1'b0;
		rf_ctl.waddr = instr.dst;
		rf_wdata     = alu_res;
		case (state_q)
			S_FILL: begin
				rf_ctl.we    = accept;
				rf_ctl.waddr = RA_W'(fill_cnt_q);
				rf_wdata     = DW'(sample);
			end
			S_EXEC: begin
				rf_ctl.we = (instr.op == OP_ADD) || (instr.op == OP_SUB) ||
					(instr.op == OP_NEG);
			end
			S_MULW: begin
				rf_ctl.we = 1'b1;
				rf_wdata  = mul_res;
			end
			default: begin
				rf_ctl.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			pc_q        <= FWD_START;
			fill_cnt_q  <= '0;
			out_cnt_q   <= '0;
			batch_q     <= 1'b0;
			dir_q       <= 1'b0;
			valid_q     <= 1'b0;
			value_q     <= '0;
			index_q     <= '0;
			last_q      <= 1'b0;
			batch_end_q <= 1'b0;
		end else begin
			valid_q <= (state_q == S_EXEC) && (instr.op == OP_OUT);
			if (cfg_we)
				dir_q <= cfg_wdata;
			case (state_q)
				S_FILL: begin
					if (accept) begin
						batch_q <= batch_q | batch_last;
						if (fill_cnt_q == LAST_FILL) begin
							fill_cnt_q <= '0;
							out_cnt_q  <= '0;
							pc_q       <= dir_q ? BWD_START : FWD_START;
							state_q    <= S_FETCH;
						end else begin
							fill_cnt_q <= fill_cnt_q + FILL_W'(1);
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (instr.op)
						OP_MUL: begin
							state_q <= S_MULW;
						end
						OP_OUT: begin
							value_q     <= sat_val;
							index_q     <= out_cnt_q;
							last_q      <= (out_cnt_q == LAST_INDEX);
							batch_end_q <= (out_cnt_q == LAST_INDEX) && batch_q;
							if (out_cnt_q == LAST_INDEX) begin
								// frame done: drop the batch mark, back to collecting
								batch_q <= 1'b0;
								state_q <= S_FILL;
							end else begin
								out_cnt_q <= out_cnt_q + INDEX_W'(1);
								pc_q      <= pc_q + PC_W'(1);
								state_q   <= S_FETCH;
							end
						end
						default: begin
							pc_q    <= pc_q + PC_W'(1);
							state_q <= S_FETCH;
						end
					endcase
				end
				S_MULW: begin
					pc_q    <= pc_q + PC_W'(1);
					state_q <= S_FETCH;
				end
				default: begin
					state_q <= S_FILL;
				end
			endcase
		end
	end

	assign valid     = valid_q;
	assign value     = value_q;
	assign index     = index_q;
	assign last      = last_q;
	assign batch_end = batch_end_q;

`ifndef SYNTHESIS
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result strobes on consecutive cycles");

	a_ninth_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fill_cnt_q == LAST_FILL) |=> busy)
		else $error("ninth item did not start the transform");

	a_mid_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("engine idle before the last result of a frame");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> !busy)
		else $error("engine still busy after the last result");

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (fill_cnt_q == '0))
		else $error("fill count not cleared while computing");
`endif

endmodule

>>> rtl/dft9_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft9_regfile: frame and scratch register file
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module dft9_regfile #(
	parameter int DW = dft9_pkg::SAMPLE_WIDTH_DEF + dft9_pkg::DATA_HEADROOM
) (
	input  logic                 clk,
	input  dft9_pkg::rf_ctl_t    ctl,
	input  logic signed [DW-1:0] wdata,
	output logic signed [DW-1:0] rdata_a,
	output logic signed [DW-1:0] rdata_b
);
	import dft9_pkg::*;

	logic signed [DW-1:0] mem [NUM_REGS];

	always_ff @(posedge clk) begin
		if (ctl.we)
			mem[ctl.waddr] <= wdata;
		rdata_a <= mem[ctl.ra];
		rdata_b <= mem[ctl.rb];
	end

endmodule

>>> rtl/dft9_mulr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dft9_mulr: shared constant multiplier
// Registers operand times coefficient, then rounds to nearest (ties up) and
// drops the fraction bits on the following cycle.
// ----------------------------------------------------------------------------
module dft9_mulr #(
	parameter int DW   = dft9_pkg::SAMPLE_WIDTH_DEF + dft9_pkg::DATA_HEADROOM,
	parameter int FRAC = dft9_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] operand,
	input  dft9_pkg::coef_t      k,
	output logic signed [DW-1:0] result
);
	import dft9_pkg::*;

	localparam int CW = FRAC + 2;
	localparam int PW = DW + CW;
	localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (FRAC - 1);

	localparam logic signed [CW-1:0] KQ_C40  = CW'(coef_round(K_C40, FRAC));
	localparam logic signed [CW-1:0] KQ_S40  = CW'(coef_round(K_S40, FRAC));
	localparam logic signed [CW-1:0] KQ_C80  = CW'(coef_round(K_C80, FRAC));
	localparam logic signed [CW-1:0] KQ_S80  = CW'(coef_round(K_S80, FRAC));
	localparam logic signed [CW-1:0] KQ_HALF = CW'(coef_round(K_HALF, FRAC));
	localparam logic signed [CW-1:0] KQ_S60  = CW'(coef_round(K_S60, FRAC));
	localparam logic signed [CW-1:0] KQ_C20  = CW'(coef_round(K_C20, FRAC));
	localparam logic signed [CW-1:0] KQ_S20  = CW'(coef_round(K_S20, FRAC));
	localparam logic signed [CW-1:0] KQ_R3   = CW'(coef_round(K_R3, FRAC));
	localparam logic signed [CW-1:0] KQ_B9   = CW'(coef_round(K_B9, FRAC));
	localparam logic signed [CW-1:0] KQ_B10  = CW'(coef_round(K_B10, FRAC));
	localparam logic signed [CW-1:0] KQ_B11  = CW'(coef_round(K_B11, FRAC));
	localparam logic signed [CW-1:0] KQ_B12  = CW'(coef_round(K_B12, FRAC));
	localparam logic signed [CW-1:0] KQ_NS60 = CW'(coef_round(K_NS60, FRAC));

	logic signed [CW-1:0] coef;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] rnd;

	always_comb begin
		case (k)
			K_C40:   coef = KQ_C40;
			K_S40:   coef = KQ_S40;
			K_C80:   coef = KQ_C80;
			K_S80:   coef = KQ_S80;
			K_HALF:  coef = KQ_HALF;
			K_S60:   coef = KQ_S60;
			K_C20:   coef = KQ_C20;
			K_S20:   coef = KQ_S20;
			K_R3:    coef = KQ_R3;
			K_B9:    coef = KQ_B9;
			K_B10:   coef = KQ_B10;
			K_B11:   coef = KQ_B11;
			K_B12:   coef = KQ_B12;
			K_NS60:  coef = KQ_NS60;
			default: coef = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(operand) * PW'(coef);
	end

	// arithmetic shift gives floor, so adding half first rounds ties upward
	assign rnd    = prod_s1 + HALF_LSB;
	assign result = DW'(rnd >>> FRAC);

endmodule

>>> tb/real_dft9_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_dft9_result_checker: predicts and checks the nine-point DFT results
// Watches the sample, configuration and result channels of the engine. Keeps
// its own frame store, batch flag and direction, works out the nine expected
// points when a frame completes and compares every strobed result with the
// oldest expected point, field by field.
// ----------------------------------------------------------------------------
module real_dft9_result_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [dft9_pkg::SAMPLE_WIDTH_DEF-1:0] sample,
	input  logic                                   batch_last,
	input  logic                                   cfg_we,
	input  logic                                   cfg_wdata,
	input  logic                                   valid,
	input  logic signed [dft9_pkg::VALUE_W-1:0]    value,
	input  logic        [dft9_pkg::INDEX_W-1:0]    index,
	input  logic                                   last,
	input  logic                                   batch_end,
	output int                                     mismatch_count,
	output int                                     points_due
);

	localparam int FRAC = dft9_pkg::COEF_FRAC_BITS_DEF;

	typedef struct packed {
		logic signed [dft9_pkg::VALUE_W-1:0] value;
		logic        [dft9_pkg::INDEX_W-1:0] index;
		logic                                last;
		logic                                batch_end;
	} point_t;

	// nearest integer of c scaled to the coefficient format, ties up
	function automatic longint to_fixed(real c);
		real scaled;
		scaled = c * real'(longint'(1) << FRAC);
		return longint'($rtoi(scaled + 0.5));
	endfunction

	localparam longint Q_C40  = to_fixed(0.766044443118978035);
	localparam longint Q_S40  = to_fixed(0.642787609686539326);
	localparam longint Q_C80  = to_fixed(0.173648177666930349);
	localparam longint Q_S80  = to_fixed(0.984807753012208059);
	localparam longint Q_HALF = to_fixed(0.5);
	localparam longint Q_S60  = to_fixed(0.866025403784438647);
	localparam longint Q_C20  = to_fixed(0.939692620785908384);
	localparam longint Q_S20  = to_fixed(0.342020143325668733);
	localparam longint Q_R3   = to_fixed(1.732050807568877294);
	localparam longint Q_B9   = to_fixed(1.705737063904886419);
	localparam longint Q_B10  = to_fixed(0.300767466360870593);
	localparam longint Q_B11  = to_fixed(1.113340798452838733);
	localparam longint Q_B12  = to_fixed(1.326827896337876792);

	longint frame_pts [9];
	longint spectrum  [9];
	int     fill;
	bit     batch_seen;
	bit     dir_q;
	int     errs;
	point_t due_q [$];

	// product rounded to the integer scale, ties up
	function automatic longint mul_round(longint v, longint k);
		return (v * k + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic signed [dft9_pkg::VALUE_W-1:0] clamp24(longint v);
		if (v > 64'sd8388607)
			return dft9_pkg::VALUE_MAX;
		if (v < -64'sd8388608)
			return dft9_pkg::VALUE_MIN;
		return v[dft9_pkg::VALUE_W-1:0];
	endfunction

	task automatic compute_frame(input bit backward);
		longint a1, d1, a2, d2, a3, d3, a4, d4, sum_a, sum_d, p60, base;
		longint t0, e0, e1, e2, e3, f4, t2, t3, f7, f8, f9, f10, f11, f12, f13, f14;
		longint f16, t7, g20, g21, g22, g26, g27, g28;
		if (!backward) begin
			a1 = frame_pts[1] + frame_pts[8];
			d1 = frame_pts[1] - frame_pts[8];
			a2 = frame_pts[2] + frame_pts[7];
			d2 = frame_pts[2] - frame_pts[7];
			a3 = frame_pts[3] + frame_pts[6];
			d3 = frame_pts[3] - frame_pts[6];
			a4 = frame_pts[4] + frame_pts[5];
			d4 = frame_pts[4] - frame_pts[5];
			sum_a = a1 + a4 + a2;
			sum_d = d1 - d2 + d4;
			p60   = mul_round(d3, Q_S60);
			base  = frame_pts[0] - mul_round(a3, Q_HALF);
			spectrum[0] = sum_a + a3 + frame_pts[0];
			spectrum[1] = base + mul_round(a1, Q_C40) + mul_round(a2, Q_C80)
				- mul_round(a4, Q_C20);
			spectrum[2] = -(mul_round(d1, Q_S40) + mul_round(d2, Q_S80) + p60
				+ mul_round(d4, Q_S20));
			spectrum[3] = base + mul_round(a4, Q_C40) + mul_round(a1, Q_C80)
				- mul_round(a2, Q_C20);
			spectrum[4] = mul_round(d4, Q_S40) - mul_round(d1, Q_S80) + p60
				- mul_round(d2, Q_S20);
			spectrum[5] = frame_pts[0] + a3 - mul_round(sum_a, Q_HALF);
			spectrum[6] = mul_round(sum_d, -Q_S60);
			spectrum[7] = base + mul_round(a2, Q_C40) + mul_round(a4, Q_C80)
				- mul_round(a1, Q_C20);
			spectrum[8] = mul_round(d2, Q_S40) + mul_round(d4, Q_S80) - p60
				- mul_round(d1, Q_S20);
		end else begin
			t0  = mul_round(frame_pts[6], Q_R3);
			e0  = frame_pts[0] - frame_pts[5];
			e1  = frame_pts[0] + 2 * frame_pts[5];
			e2  = e0 - t0;
			e3  = e0 + t0;
			f4  = frame_pts[7] + frame_pts[3];
			t2  = mul_round(frame_pts[7] - frame_pts[3], Q_S60);
			t3  = mul_round(frame_pts[8] + frame_pts[4], Q_S60);
			f7  = frame_pts[4] - frame_pts[8];
			f8  = frame_pts[1] + f4;
			f9  = frame_pts[2] + mul_round(f7, Q_HALF);
			f10 = t2 + f9;
			f11 = f9 - t2;
			f12 = frame_pts[1] - mul_round(f4, Q_HALF);
			f13 = f12 - t3;
			f14 = f12 + t3;
			f16 = e1 - f8;
			t7  = mul_round(frame_pts[2] - f7, Q_R3);
			g20 = mul_round(f13, Q_C40) - mul_round(f10, Q_S40);
			g21 = mul_round(f13, Q_B11) + mul_round(f10, Q_B12);
			g22 = e2 - g20;
			g26 = mul_round(f14, Q_B9) + mul_round(f11, Q_B10);
			g27 = mul_round(f14, Q_C80) - mul_round(f11, Q_S80);
			g28 = e3 - g27;
			spectrum[0] = e1 + 2 * f8;
			spectrum[1] = e2 + 2 * g20;
			spectrum[2] = e3 + 2 * g27;
			spectrum[3] = f16 - t7;
			spectrum[4] = g22 - g21;
			spectrum[5] = g28 - g26;
			spectrum[6] = f16 + t7;
			spectrum[7] = g22 + g21;
			spectrum[8] = g28 + g26;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_t got;
		point_t want;
		if (!arst_n) begin
			fill           = 0;
			batch_seen     = 1'b0;
			dir_q          = 1'b0;
			errs           = 0;
			due_q.delete();
			mismatch_count <= 0;
			points_due     <= 0;
		end else begin
			if (valid) begin
				got.value     = value;
				got.index     = index;
				got.last      = last;
				got.batch_end = batch_end;
				if (due_q.size() == 0) begin
					$error("result with nothing due: value %0d index %0d", got.value, got.index);
					errs++;
				end else begin
					want = due_q.pop_front();
					if (got.value !== want.value) begin
						$error("value mismatch: expected %0d, got %0d", want.value, got.value);
						errs++;
					end
					if (got.index !== want.index) begin
						$error("index mismatch: expected %0d, got %0d", want.index, got.index);
						errs++;
					end
					if (got.last !== want.last) begin
						$error("last mismatch: expected %0d, got %0d", want.last, got.last);
						errs++;
					end
					if (got.batch_end !== want.batch_end) begin
						$error("batch_end mismatch: expected %0d, got %0d",
							want.batch_end, got.batch_end);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				frame_pts[fill] = longint'(sample);
				batch_seen      = batch_seen | batch_last;
				fill++;
				if (fill == 9) begin
					compute_frame(dir_q);
					for (int k = 0; k < 9; k++) begin
						want.value     = clamp24(spectrum[k]);
						want.index     = dft9_pkg::INDEX_W'(k);
						want.last      = (k == 8);
						want.batch_end = (k == 8) && batch_seen;
						due_q.push_back(want);
					end
					fill       = 0;
					batch_seen = 1'b0;
				end
			end
			if (cfg_we)
				dir_q = cfg_wdata;
			mismatch_count <= errs;
			points_due     <= due_q.size();
		end
	end

endmodule

>>> tb/real_dft9_halfcomplex_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// real_dft9_halfcomplex_engine_test: stimulus and verdict for the DFT engine
// Runs directed frames at the sample extremes, in both directions, with a
// direction change part way through a frame and batch marks, then random
// frames in alternating-direction phases, in gapped bursts save each 4th phase.
// ----------------------------------------------------------------------------
module real_dft9_halfcomplex_engine_test;

	localparam int  SW        = dft9_pkg::SAMPLE_WIDTH_DEF;
	localparam int  ITEMS     = 370;
	localparam int  SETTLE    = 12;
	localparam int  MAX_CYCLES = 400000;
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [SW-1:0]                sample;
	logic                                batch_last;
	logic                                cfg_we;
	logic                                cfg_wdata;
	logic                                valid;
	logic signed [dft9_pkg::VALUE_W-1:0] value;
	logic        [dft9_pkg::INDEX_W-1:0] index;
	logic                                last;
	logic                                batch_end;
	int                                  mismatch_count;
	int                                  points_due;
	int                                  cycles;

	real_dft9_halfcomplex_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.batch_last (batch_last),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.valid      (valid),
		.value      (value),
		.index      (index),
		.last       (last),
		.batch_end  (batch_end)
	);

	real_dft9_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.sample         (sample),
		.batch_last     (batch_last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.valid          (valid),
		.value          (value),
		.index          (index),
		.last           (last),
		.batch_end      (batch_end),
		.mismatch_count (mismatch_count),
		.points_due     (points_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hold the item until the engine takes it
	task automatic push_sample(input logic signed [SW-1:0] s, input logic bl);
		start      <= 1'b1;
		sample     <= s;
		batch_last <= bl;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait for every due point and for the engine to go quiet
	task automatic drain_points();
		start <= 1'b0;
		@(posedge clk);
		while (points_due != 0 || busy)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_direction(input logic dir);
		drain_points();
		cfg_we    <= 1'b1;
		cfg_wdata <= dir;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			3:       return SW'($urandom_range(0, 31)) - SW'(16);
			default: return SW'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [SW-1:0] mixed [9];
		int  sent;
		int  phase;
		int  frames;
		int  burst_left;
		bit  steady;
		arst_n     = 1'b0;
		start      = 1'b0;
		sample     = '0;
		batch_last = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		cycles     = 0;
		mixed      = '{S_MAX, S_MIN, '0, SW'(1), -SW'(1), S_MAX, S_MIN, S_MAX, S_MIN};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// forward, full scale positive, batch mark in the middle of the frame
		write_direction(1'b0);
		for (int k = 0; k < 9; k++)
			push_sample(S_MAX, k == 3);
		// direction flipped after four items: the ninth item decides
		for (int k = 0; k < 4; k++)
			push_sample(S_MIN, 1'b0);
		write_direction(1'b1);
		for (int k = 0; k < 5; k++)
			push_sample(S_MIN, 1'b0);
		// backward, mixed extremes, batch mark on the ninth item
		for (int k = 0; k < 9; k++)
			push_sample(mixed[k], k == 8);
		drain_points();

		// the three directed frames count toward the total
		sent       = 3 * 9;
		phase      = 0;
		burst_left = $urandom_range(1, 24);
		while (sent < ITEMS) begin
			write_direction(phase[0]);
			steady = (phase % 4 == 3);
			frames = $urandom_range(2, 6);
			for (int f = 0; f < frames && sent < ITEMS; f++) begin
				for (int k = 0; k < 9; k++) begin
					push_sample(pick_sample(), $urandom_range(0, 11) == 0);
					sent++;
					if (!steady) begin
						if (burst_left == 0) begin
							idle_cycles($urandom_range(1, 8));
							burst_left = $urandom_range(1, 24);
						end else begin
							burst_left--;
						end
					end
				end
				if ($urandom_range(0, 5) == 0)
					drain_points();
			end
			phase++;
		end

		drain_points();
		if (mismatch_count == 0 && points_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/dft9_pkg.sv
rtl/dft9_regfile.sv
rtl/dft9_mulr.sv
rtl/real_dft9_halfcomplex_engine.sv
tb/real_dft9_result_checker.sv
tb/real_dft9_halfcomplex_engine_test.sv
